>>> rtl/core/sorted_unique_key_set_unit_defines.svh
// Assertion helpers used by the checker file.
`ifndef SORTED_UNIQUE_KEY_SET_UNIT_DEFINES_SVH
`define SORTED_UNIQUE_KEY_SET_UNIT_DEFINES_SVH

// Same-cycle implication, masked while reset is asserted.
`define SUS_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, masked while reset is asserted.
`define SUS_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/sus_pkg.sv
package sus_pkg;

    localparam int CAPACITY_DEFAULT = 64;

    localparam int KEY_W     = 32;
    localparam int OP_W      = 2;
    localparam int STATUS_W  = 2;
    localparam int POS_W     = 6;
    localparam int CNT_OUT_W = 7;

    // Request tdata: opcode, key, zero padding up to whole bytes.
    localparam int IN_USED_W  = OP_W + KEY_W;
    localparam int IN_DATA_W  = ((IN_USED_W + 7) / 8) * 8;
    localparam int I_KEY_LSB  = OP_W;

    // Result tdata: status, position, entry_count, smallest, largest, set_empty.
    localparam int O_POS_LSB   = STATUS_W;
    localparam int O_CNT_LSB   = O_POS_LSB + POS_W;
    localparam int O_SMALL_LSB = O_CNT_LSB + CNT_OUT_W;
    localparam int O_LARGE_LSB = O_SMALL_LSB + KEY_W;
    localparam int O_EMPTY_BIT = O_LARGE_LSB + KEY_W;
    localparam int OUT_USED_W  = O_EMPTY_BIT + 1;
    localparam int OUT_DATA_W  = ((OUT_USED_W + 7) / 8) * 8;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_SEARCH = 2'd2
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_SHIFT_UP,
        S_SHIFT_DN,
        S_PUT,
        S_REF0,
        S_REF1,
        S_REF2,
        S_DONE
    } seq_state_t;

    typedef struct packed {
        status_t                      status;
        logic [POS_W-1:0]             position;
        logic [CNT_OUT_W-1:0]         entry_count;
        logic signed [KEY_W-1:0]      smallest_key;
        logic signed [KEY_W-1:0]      largest_key;
        logic                         set_empty;
    } sus_result_t;

endpackage

>>> rtl/core/sorted_unique_key_set_unit.sv
// A request is scanned, decided, shifted or written as needed, and the end keys refreshed,
// then the result enters the output register. The scan reads one entry a cycle and the shift
// moves one entry a cycle through the key RAM. One request is in work at a time; the next is
// accepted in the cycle after the result enters the output register, so a result stall also
// holds off the next request. Reset clears the count and the control state; the key RAM keeps
// its contents, and keys at or above the count never reach a result.
module sorted_unique_key_set_unit #(
    parameter int CAPACITY = sus_pkg::CAPACITY_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // Request side.
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [sus_pkg::IN_DATA_W-1:0]    s_tdata,  // opcode, key, zero pad
    // Result side.
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [sus_pkg::OUT_DATA_W-1:0]   m_tdata   // status, position, entry_count,
                                                       // smallest_key, largest_key, set_empty
);

    localparam int AW = $clog2(CAPACITY);

    sus_pkg::opcode_t                 req_op;
    logic signed [sus_pkg::KEY_W-1:0] req_key;

    logic                             res_valid;
    logic                             res_ready;
    sus_pkg::sus_result_t             res;

    logic                             rd_en;
    logic [AW-1:0]                    rd_addr;
    logic [sus_pkg::KEY_W-1:0]        rd_data;
    logic                             wr_en;
    logic [AW-1:0]                    wr_addr;
    logic [sus_pkg::KEY_W-1:0]        wr_data;

    // Unpack the request: opcode in the low bits, key above it.
    assign req_op  = sus_pkg::opcode_t'(s_tdata[sus_pkg::OP_W-1:0]);
    assign req_key = $signed(s_tdata[sus_pkg::I_KEY_LSB +: sus_pkg::KEY_W]);

    // Sequencer: linear scan for the lower bound, then shift and refresh ends.
    sus_seq #(
        .CAPACITY (CAPACITY)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (s_tvalid),
        .req_ready (s_tready),
        .req_op    (req_op),
        .req_key   (req_key),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data)
    );

    // Ordered key store, kept ascending in entries 0..count-1.
    sus_ram #(
        .WIDTH (sus_pkg::KEY_W),
        .DEPTH (CAPACITY)
    ) u_key_ram (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    // Output register: hold the result while the consumer stalls.
    sus_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

>>> rtl/core/sus_ram.sv
module sus_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/core/sus_seq.sv
module sus_seq #(
    parameter int CAPACITY = sus_pkg::CAPACITY_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                req_valid,
    output logic                                req_ready,
    input  sus_pkg::opcode_t                    req_op,
    input  logic signed [sus_pkg::KEY_W-1:0]    req_key,
    output logic                                res_valid,
    input  logic                                res_ready,
    output sus_pkg::sus_result_t                res,
    output logic                                rd_en,
    output logic [$clog2(CAPACITY)-1:0]         rd_addr,
    input  logic [sus_pkg::KEY_W-1:0]           rd_data,
    output logic                                wr_en,
    output logic [$clog2(CAPACITY)-1:0]         wr_addr,
    output logic [sus_pkg::KEY_W-1:0]           wr_data
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    sus_pkg::seq_state_t state_reg, state_next;
    logic [CW-1:0]       count_reg, count_next;
    logic                pend_reg, pend_next;
    logic                issue_reg, issue_next;

    sus_pkg::opcode_t               op_reg, op_next;
    logic signed [sus_pkg::KEY_W-1:0] key_reg, key_next;
    logic [CW-1:0]                  idx_reg, idx_next;
    logic [CW-1:0]                  widx_reg, widx_next;
    logic [CW-1:0]                  at_reg, at_next;
    logic                           found_reg, found_next;
    sus_pkg::status_t               status_reg, status_next;
    logic [AW-1:0]                  pos_reg, pos_next;
    logic [sus_pkg::KEY_W-1:0]      small_reg, small_next;
    logic [sus_pkg::KEY_W-1:0]      large_reg, large_next;

    logic                           hit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sus_pkg::S_IDLE;
            count_reg <= '0;
            pend_reg  <= 1'b0;
            issue_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
            issue_reg <= issue_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        key_reg    <= key_next;
        idx_reg    <= idx_next;
        widx_reg   <= widx_next;
        at_reg     <= at_next;
        found_reg  <= found_next;
        status_reg <= status_next;
        pos_reg    <= pos_next;
        small_reg  <= small_next;
        large_reg  <= large_next;
    end

    // Stored key at or above the request key ends the scan.
    assign hit = pend_reg && ($signed(rd_data) >= key_reg);

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        pend_next   = pend_reg;
        issue_next  = issue_reg;
        op_next     = op_reg;
        key_next    = key_reg;
        idx_next    = idx_reg;
        widx_next   = widx_reg;
        at_next     = at_reg;
        found_next  = found_reg;
        status_next = status_reg;
        pos_next    = pos_reg;
        small_next  = small_reg;
        large_next  = large_reg;

        req_ready = 1'b0;
        res_valid = 1'b0;
        rd_en     = 1'b0;
        rd_addr   = idx_reg[AW-1:0];
        wr_en     = 1'b0;
        wr_addr   = at_reg[AW-1:0];
        wr_data   = rd_data;

        unique case (state_reg)
            sus_pkg::S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    op_next     = req_op;
                    key_next    = req_key;
                    idx_next    = '0;
                    pend_next   = 1'b0;
                    status_next = sus_pkg::ST_MISS;
                    pos_next    = '0;
                    if (count_reg == '0)
                    begin
                        at_next    = '0;
                        found_next = 1'b0;
                        state_next = sus_pkg::S_DECIDE;
                    end
                    else
                    begin
                        state_next = sus_pkg::S_SCAN;
                    end
                end
            end

            sus_pkg::S_SCAN:
            begin
                if (hit)
                begin
                    at_next    = idx_reg - CW'(1);
                    found_next = (rd_data == key_reg);
                    pend_next  = 1'b0;
                    state_next = sus_pkg::S_DECIDE;
                end
                else if (pend_reg && (idx_reg == count_reg))
                begin
                    at_next    = count_reg;
                    found_next = 1'b0;
                    pend_next  = 1'b0;
                    state_next = sus_pkg::S_DECIDE;
                end
                else if (idx_reg < count_reg)
                begin
                    rd_en     = 1'b1;
                    idx_next  = idx_reg + CW'(1);
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                end
            end

            sus_pkg::S_DECIDE:
            begin
                state_next = sus_pkg::S_REF0;
                unique case (op_reg)
                    sus_pkg::OP_INSERT:
                    begin
                        if (found_reg)
                        begin
                            status_next = sus_pkg::ST_MISS;
                        end
                        else if (count_reg == CW'(CAPACITY))
                        begin
                            status_next = sus_pkg::ST_FULL;
                        end
                        else
                        begin
                            status_next = sus_pkg::ST_DONE;
                            pos_next    = at_reg[AW-1:0];
                            if (at_reg == count_reg)
                            begin
                                state_next = sus_pkg::S_PUT;
                            end
                            else
                            begin
                                idx_next   = count_reg - CW'(1);
                                issue_next = 1'b1;
                                pend_next  = 1'b0;
                                state_next = sus_pkg::S_SHIFT_UP;
                            end
                        end
                    end
                    sus_pkg::OP_DELETE:
                    begin
                        if (found_reg)
                        begin
                            status_next = sus_pkg::ST_DONE;
                            pos_next    = at_reg[AW-1:0];
                            if (at_reg == count_reg - CW'(1))
                            begin
                                count_next = count_reg - CW'(1);
                            end
                            else
                            begin
                                idx_next   = at_reg + CW'(1);
                                issue_next = 1'b1;
                                pend_next  = 1'b0;
                                state_next = sus_pkg::S_SHIFT_DN;
                            end
                        end
                    end
                    sus_pkg::OP_SEARCH:
                    begin
                        if (found_reg)
                        begin
                            status_next = sus_pkg::ST_DONE;
                            pos_next    = at_reg[AW-1:0];
                        end
                    end
                    default:
                    begin
                        status_next = sus_pkg::ST_MISS;
                    end
                endcase
            end

            // Move entries at..count-1 one place up, top first.
            sus_pkg::S_SHIFT_UP:
            begin
                if (pend_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = AW'(widx_reg + CW'(1));
                    wr_data = rd_data;
                end
                if (issue_reg)
                begin
                    rd_en     = 1'b1;
                    widx_next = idx_reg;
                    pend_next = 1'b1;
                    if (idx_reg == at_reg)
                    begin
                        issue_next = 1'b0;
                    end
                    else
                    begin
                        idx_next = idx_reg - CW'(1);
                    end
                end
                else
                begin
                    pend_next  = 1'b0;
                    state_next = sus_pkg::S_PUT;
                end
            end

            // Move entries at+1..count-1 one place down, bottom first.
            sus_pkg::S_SHIFT_DN:
            begin
                if (pend_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = AW'(widx_reg - CW'(1));
                    wr_data = rd_data;
                end
                if (issue_reg)
                begin
                    rd_en     = 1'b1;
                    widx_next = idx_reg;
                    pend_next = 1'b1;
                    if (idx_reg == count_reg - CW'(1))
                    begin
                        issue_next = 1'b0;
                    end
                    else
                    begin
                        idx_next = idx_reg + CW'(1);
                    end
                end
                else
                begin
                    pend_next  = 1'b0;
                    count_next = count_reg - CW'(1);
                    state_next = sus_pkg::S_REF0;
                end
            end

            sus_pkg::S_PUT:
            begin
                wr_en      = 1'b1;
                wr_addr    = at_reg[AW-1:0];
                wr_data    = key_reg;
                count_next = count_reg + CW'(1);
                state_next = sus_pkg::S_REF0;
            end

            sus_pkg::S_REF0:
            begin
                rd_en      = 1'b1;
                rd_addr    = '0;
                state_next = sus_pkg::S_REF1;
            end

            sus_pkg::S_REF1:
            begin
                small_next = rd_data;
                rd_en      = 1'b1;
                rd_addr    = AW'(count_reg - CW'(1));
                state_next = sus_pkg::S_REF2;
            end

            sus_pkg::S_REF2:
            begin
                large_next = rd_data;
                state_next = sus_pkg::S_DONE;
            end

            sus_pkg::S_DONE:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = sus_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = sus_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        res.status      = status_reg;
        res.position    = sus_pkg::POS_W'(pos_reg);
        res.entry_count = sus_pkg::CNT_OUT_W'(count_reg);
        res.set_empty   = (count_reg == '0);
        if (count_reg == '0)
        begin
            res.smallest_key = '0;
            res.largest_key  = '0;
        end
        else
        begin
            res.smallest_key = $signed(small_reg);
            res.largest_key  = $signed(large_reg);
        end
    end

endmodule

>>> rtl/core/sus_out_stage.sv
module sus_out_stage (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              res_valid,
    output logic                              res_ready,
    input  sus_pkg::sus_result_t              res,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [sus_pkg::OUT_DATA_W-1:0]    m_tdata
);

    logic                 valid_reg;
    sus_pkg::sus_result_t data_reg;

    // Take a new result when empty or when the held one leaves this cycle.
    assign res_ready = !valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            data_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = sus_pkg::OUT_DATA_W'({data_reg.set_empty,
                                            data_reg.largest_key,
                                            data_reg.smallest_key,
                                            data_reg.entry_count,
                                            data_reg.position,
                                            data_reg.status});

endmodule

>>> rtl/core/sus_checker.sv
`include "sorted_unique_key_set_unit_defines.svh"

module sus_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    input  logic [sus_pkg::IN_DATA_W-1:0]    s_tdata,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [sus_pkg::OUT_DATA_W-1:0]   m_tdata
);

    logic [sus_pkg::STATUS_W-1:0]  r_status;
    logic [sus_pkg::POS_W-1:0]     r_pos;
    logic [sus_pkg::CNT_OUT_W-1:0] r_cnt;
    logic [sus_pkg::KEY_W-1:0]     r_small;
    logic [sus_pkg::KEY_W-1:0]     r_large;
    logic                          r_empty;
    logic                          in_take;

    assign r_status = m_tdata[sus_pkg::STATUS_W-1:0];
    assign r_pos    = m_tdata[sus_pkg::O_POS_LSB +: sus_pkg::POS_W];
    assign r_cnt    = m_tdata[sus_pkg::O_CNT_LSB +: sus_pkg::CNT_OUT_W];
    assign r_small  = m_tdata[sus_pkg::O_SMALL_LSB +: sus_pkg::KEY_W];
    assign r_large  = m_tdata[sus_pkg::O_LARGE_LSB +: sus_pkg::KEY_W];
    assign r_empty  = m_tdata[sus_pkg::O_EMPTY_BIT];
    assign in_take  = s_tvalid && s_tready && (s_tdata != s_tdata + 1'b1);

    `SUS_ASSERT_NXT(a_res_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")
    `SUS_ASSERT_IMP(a_empty_ends, clk, rst_n, m_tvalid && r_empty, r_cnt == '0 && r_small == '0 && r_large == '0, "empty set reports keys or count")
    `SUS_ASSERT_IMP(a_miss_pos, clk, rst_n, m_tvalid && r_status != sus_pkg::ST_DONE, r_pos == '0, "refused request reports a position")
    `SUS_ASSERT_NXT(a_one_request, clk, rst_n, in_take, !s_tready, "second request taken while one is in work")

endmodule

bind sorted_unique_key_set_unit sus_checker u_sus_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

>>> verif/testbench.sv
module testbench;

    import sus_pkg::*;

    localparam int CAP         = CAPACITY_DEFAULT;
    localparam int LIMIT       = 600000;     // generous bound on the whole run, in cycles
    localparam int LONG_HOLD   = 300;        // receiver hold-off that backs the block up
    localparam int DRAIN_WAIT  = 2 * CAP + 20;
    localparam int RANDOM_RUNS = 135;        // requests per random phase, four phases

    localparam logic [OP_W-1:0]         OP_UNUSED = 2'd3;
    localparam logic signed [KEY_W-1:0] KEY_MIN   = 32'sh8000_0000;
    localparam logic signed [KEY_W-1:0] KEY_MAX   = 32'sh7FFF_FFFF;

    // Tracks the ordered key set and the results it should produce, oldest first.
    class key_set_tracker;
        logic signed [KEY_W-1:0] held_keys [CAP];
        int                      held_total;
        sus_result_t             pending_results [$];
        int                      mismatches;
        int                      results_seen;

        function new();
            held_total   = 0;
            mismatches   = 0;
            results_seen = 0;
        endfunction

        // Apply one accepted request to the set and queue the result it gives.
        function void record_request(logic [OP_W-1:0] op, logic signed [KEY_W-1:0] key);
            sus_result_t want;
            int          at;
            bit          found;
            at = 0;
            while (at < held_total && held_keys[at] < key)
                at++;
            found         = (at < held_total) && (held_keys[at] == key);
            want.status   = ST_MISS;
            want.position = '0;
            case (op)
                OP_INSERT:
                    if (!found && held_total >= CAP) begin
                        want.status = ST_FULL;
                    end
                    else if (!found) begin
                        for (int i = held_total; i > at; i--)
                            held_keys[i] = held_keys[i-1];
                        held_keys[at] = key;
                        held_total++;
                        want.status   = ST_DONE;
                        want.position = POS_W'(at);
                    end
                OP_DELETE:
                    if (found) begin
                        for (int i = at; i < held_total - 1; i++)
                            held_keys[i] = held_keys[i+1];
                        held_total--;
                        want.status   = ST_DONE;
                        want.position = POS_W'(at);
                    end
                OP_SEARCH:
                    if (found) begin
                        want.status   = ST_DONE;
                        want.position = POS_W'(at);
                    end
                default: ;
            endcase
            want.entry_count = CNT_OUT_W'(held_total);
            want.set_empty   = (held_total == 0);
            want.smallest_key = (held_total == 0) ? '0 : held_keys[0];
            want.largest_key  = (held_total == 0) ? '0 : held_keys[held_total-1];
            pending_results.push_back(want);
        endfunction

        function void compare_field(string label, logic [KEY_W-1:0] want,
                                    logic [KEY_W-1:0] got);
            if (want !== got) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch in %s of result %0d: expected %0h, got %0h",
                             label, results_seen, want, got);
            end
        endfunction

        // Compare one accepted result, field by field, with the oldest expectation.
        function void check_result(logic [OUT_DATA_W-1:0] word);
            sus_result_t want;
            results_seen++;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result %0d (%0h) arrived with nothing pending",
                             results_seen, word);
                return;
            end
            want = pending_results.pop_front();
            compare_field("status",       want.status,       word[O_POS_LSB-1:0]);
            compare_field("position",     want.position,     word[O_CNT_LSB-1:O_POS_LSB]);
            compare_field("entry_count",  want.entry_count,  word[O_SMALL_LSB-1:O_CNT_LSB]);
            compare_field("smallest_key", want.smallest_key, word[O_LARGE_LSB-1:O_SMALL_LSB]);
            compare_field("largest_key",  want.largest_key,  word[O_EMPTY_BIT-1:O_LARGE_LSB]);
            compare_field("set_empty",    want.set_empty,    word[O_EMPTY_BIT]);
        endfunction
    endclass

    logic                    clk      = 1'b0;
    logic                    rst_n    = 1'b0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [IN_DATA_W-1:0]    s_tdata  = '0;   // opcode, key, zero pad
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [OUT_DATA_W-1:0]   m_tdata;         // status, position, entry_count,
                                              // smallest_key, largest_key, set_empty

    int              send_idle_pct  = 0;
    int              recv_stall_pct = 0;
    bit              hold_pending   = 1'b0;
    bit              filling        = 1'b1;
    int              full_hits      = 0;
    int              cycles         = 0;
    key_set_tracker  tracker        = new();

    sorted_unique_key_set_unit #(
        .CAPACITY (CAP)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // Watch both handshakes; values read here are the ones from before the edge.
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
            tracker.record_request(s_tdata[OP_W-1:0], s_tdata[I_KEY_LSB +: KEY_W]);
        if (rst_n && m_tvalid && m_tready)
            tracker.check_result(m_tdata);
    end

    // Receiver: stall at random, or hold off for a long stretch when asked.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_pending)
            begin
                hold_pending = 1'b0;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Watchdog: end the run with an error once the cycle bound is reached.
    initial
    begin
        while (cycles < LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    // Offer one request, idling first at random, and hold it until accepted.
    task automatic send_request(logic [OP_W-1:0] op, logic signed [KEY_W-1:0] key);
        logic [IN_DATA_W-1:0] word;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        word                       = '0;
        word[OP_W-1:0]             = op;
        word[I_KEY_LSB +: KEY_W]   = key;
        s_tdata  <= word;
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // Pick a key: a held one, a neighbor of a held one, an extreme, a value at or next to zero, or anything.
    function automatic logic signed [KEY_W-1:0] pick_key(int held_pct);
        logic signed [KEY_W-1:0] base;
        int                      r;
        r    = $urandom_range(0, 99);
        base = (tracker.held_total > 0)
             ? tracker.held_keys[$urandom_range(0, tracker.held_total - 1)] : '0;
        if (tracker.held_total > 0 && r < held_pct)
            return base;
        if (tracker.held_total > 0 && r < held_pct + 15)
            return $urandom_range(0, 1) ? base + 1 : base - 1;
        if (r < held_pct + 25)
        begin
            case ($urandom_range(0, 4))
                0:       return KEY_MIN;
                1:       return KEY_MAX;
                2:       return '0;
                3:       return -1;
                default: return 1;
            endcase
        end
        return $urandom;
    endfunction

    task automatic run_directed();
        logic [OP_W-1:0] ops [23] = '{
            OP_SEARCH, OP_DELETE, OP_UNUSED, OP_INSERT, OP_DELETE, OP_INSERT,
            OP_INSERT, OP_INSERT, OP_INSERT, OP_INSERT, OP_INSERT, OP_SEARCH,
            OP_SEARCH, OP_SEARCH, OP_SEARCH, OP_UNUSED, OP_DELETE, OP_DELETE,
            OP_DELETE, OP_DELETE, OP_DELETE, OP_DELETE, OP_SEARCH};
        logic signed [KEY_W-1:0] keys [23] = '{
            5, 5, 5, 0, 0, KEY_MAX,
            KEY_MIN, 0, -1, 1, 0, KEY_MIN,
            KEY_MAX, -1, 2, KEY_MAX, 0, KEY_MIN,
            KEY_MAX, 7, -1, 1, 1};
        // Empty set first, then the only key deleted, signed order across zero,
        // a duplicate, misses, the unused opcode, and a drain back to empty.
        for (int i = 0; i < 23; i++)
            send_request(ops[i], keys[i]);
    endtask

    // Alternate between filling the store past full and draining it near empty.
    task automatic run_phase(int count, bit with_hold);
        logic [OP_W-1:0] op;
        int              r;
        for (int n = 0; n < count; n++)
        begin
            if (with_hold && n == count / 3)
                hold_pending = 1'b1;
            r = $urandom_range(0, 99);
            if (filling)
                op = (r < 80) ? OP_INSERT : (r < 88) ? OP_DELETE
                   : (r < 96) ? OP_SEARCH : OP_UNUSED;
            else
                op = (r < 15) ? OP_INSERT : (r < 75) ? OP_DELETE
                   : (r < 95) ? OP_SEARCH : OP_UNUSED;
            send_request(op, pick_key(op == OP_INSERT ? 20 : 60));
            // Linger at full for a while so full and duplicate-at-full refusals occur.
            if (filling && tracker.held_total == CAP)
                full_hits++;
            if (filling && full_hits >= 10)
                filling = 1'b0;
            else if (!filling && tracker.held_total <= $urandom_range(0, 2))
            begin
                filling   = 1'b1;
                full_hits = 0;
            end
        end
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();

        // Steady offering while the receiver holds off, then each idling mix.
        run_phase(RANDOM_RUNS, 1'b1);
        send_idle_pct  = 47;
        run_phase(RANDOM_RUNS, 1'b0);
        send_idle_pct  = 0;
        recv_stall_pct = 47;
        run_phase(RANDOM_RUNS, 1'b0);
        send_idle_pct  = 23;
        recv_stall_pct = 23;
        run_phase(RANDOM_RUNS, 1'b0);
        s_tvalid <= 1'b0;

        while (tracker.pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (tracker.mismatches == 0 && tracker.pending_results.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
